/* hw/rtl/aesenc_pkg.sv */
// Package for the AES block encryptor: cipher constants, the S-box and helper functions.
// Used by aesenc_key_store, aesenc_round and aes_block_encrypt.
package aesenc_pkg;

  localparam int unsigned BlockW   = 128;
  localparam int unsigned HalfW    = 64;
  localparam logic [7:0]  GfPoly   = 8'h1B;
  localparam logic [4:0]  RoundBase = 5'd6;

  typedef enum logic [0:0] {
    OP_LOAD    = 1'b0,
    OP_ENCRYPT = 1'b1
  } op_t;

  // Substitution table of the cipher.
  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  // Multiplication by x in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
  endfunction

  // Byte i of a block sits at bits [127-8i -: 8].
  function automatic logic [7:0] get_byte(input logic [BlockW-1:0] s, input int unsigned i);
    return s[BlockW-1-8*i -: 8];
  endfunction

endpackage

/* hw/rtl/aes_block_encrypt.sv */
// Top level of the AES block encryptor with software-loaded round keys.
// Depends on aesenc_pkg, aesenc_key_store and aesenc_round.
//
// Usage: raise start with in_op, in_key_slot, in_block_hi and in_block_lo; the item
// is taken at a clock edge where start is high and busy is low.
// A load item (in_op = 0) writes one round key into the key memory in that same edge
// and gives no result; busy stays low, so the next item may follow at once.
// A load to a slot at or beyond MAX_ROUND_KEYS is dropped.
// An encrypt item (in_op = 1) runs N = min(6 + key_words, MAX_ROUND_KEYS - 1) rounds.
// The key memory has a registered read port; each round reads one key, and the final
// AddRoundKey one more, so after acceptance the item passes through ST_FETCH and then
// ST_ROUND for round counts 0 to N before out_valid; busy is high until out_valid rises.
// out_valid pulses for one cycle with out_cipher_hi / out_cipher_lo; the receiver
// cannot stall and must take the item then.
// cfg_we writes key_words (cfg_wdata); the user must do so while the block is idle (not enforced).
// Reset (rst_n low, synchronous) sets key_words to 4 and returns to idle; the key
// memory keeps its contents and a never-loaded slot reads as anything.
module aes_block_encrypt #(
  parameter int unsigned MAX_ROUND_KEYS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [3:0]  in_key_slot,
  input  logic [63:0] in_block_hi,
  input  logic [63:0] in_block_lo,
  output logic        out_valid,
  output logic [63:0] out_cipher_hi,
  output logic [63:0] out_cipher_lo,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);

  localparam int unsigned AddrW = $clog2(MAX_ROUND_KEYS);
  localparam logic [4:0] MaxRounds = 5'(MAX_ROUND_KEYS - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_ROUND = 3'b100
  } state_t;

  state_t                        state_r, state_nxt;
  logic [3:0]                    key_words_r;
  logic [AddrW-1:0]              rd_addr_r, rd_addr_nxt;
  logic [4:0]                    round_r, round_nxt;
  logic [4:0]                    rounds_r;
  logic [aesenc_pkg::BlockW-1:0] blk_r, blk_nxt;
  logic [aesenc_pkg::BlockW-1:0] key_q;
  logic [aesenc_pkg::BlockW-1:0] round_out;
  logic                          out_valid_r, out_valid_nxt;
  logic [aesenc_pkg::BlockW-1:0] cipher_r;
  logic                          accept;
  logic                          wr_en;
  logic [4:0]                    rounds_calc;

  assign accept = start && (state_r == ST_IDLE);
  assign wr_en  = accept && (in_op == aesenc_pkg::OP_LOAD)
                  && ({1'b0, in_key_slot} < 5'(MAX_ROUND_KEYS));
  assign rounds_calc = (aesenc_pkg::RoundBase + {1'b0, key_words_r} > MaxRounds)
                       ? MaxRounds : aesenc_pkg::RoundBase + {1'b0, key_words_r};

  aesenc_key_store #(.Depth(MAX_ROUND_KEYS)) u_keys (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_key_slot[AddrW-1:0]),
    .wr_data ({in_block_hi, in_block_lo}),
    .rd_addr (rd_addr_r),
    .rd_data (key_q)
  );

  aesenc_round u_round (
    .state_in  (blk_r),
    .round_key (key_q),
    .last      (round_r + 5'd1 == rounds_r),
    .state_out (round_out)
  );

  // Round sequencer: the key of round r is requested in the cycle before it is used.
  always_comb begin
    state_nxt     = state_r;
    rd_addr_nxt   = rd_addr_r;
    round_nxt     = round_r;
    blk_nxt       = blk_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_op == aesenc_pkg::OP_ENCRYPT) begin
          state_nxt   = ST_FETCH;
          blk_nxt     = {in_block_hi, in_block_lo};
          rd_addr_nxt = '0;
          round_nxt   = '0;
        end
      end
      ST_FETCH: begin
        state_nxt   = ST_ROUND;
        rd_addr_nxt = AddrW'(1);
      end
      ST_ROUND: begin
        if (round_r == rounds_r) begin
          // Final AddRoundKey.
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          blk_nxt     = round_out;
          round_nxt   = round_r + 5'd1;
          rd_addr_nxt = rd_addr_r + AddrW'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      key_words_r <= 4'd4;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        key_words_r <= cfg_wdata;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    round_r   <= round_nxt;
    blk_r     <= blk_nxt;
    if (accept) begin
      rounds_r <= rounds_calc;
    end
    if (out_valid_nxt) begin
      cipher_r <= blk_r ^ key_q;
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_cipher_hi = cipher_r[127:64];
  assign out_cipher_lo = cipher_r[63:0];

endmodule

/* hw/rtl/aesenc_key_store.sv */
// Round key memory: one 128-bit round key per entry, registered synchronous read.
// Depends on aesenc_pkg for the block width.
module aesenc_key_store #(
  parameter int unsigned Depth = 15
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(Depth)-1:0]         wr_addr,
  input  logic [aesenc_pkg::BlockW-1:0]    wr_data,
  input  logic [$clog2(Depth)-1:0]         rd_addr,
  output logic [aesenc_pkg::BlockW-1:0]    rd_data
);

  logic [aesenc_pkg::BlockW-1:0] mem [Depth];

  // Write port; out-of-range slots are filtered by the caller.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/aesenc_round.sv */
// One cipher round: AddRoundKey, SubBytes with ShiftRows, and MixColumns unless last.
// Depends on aesenc_pkg for the S-box and GF helpers.
module aesenc_round (
  input  logic [aesenc_pkg::BlockW-1:0] state_in,
  input  logic [aesenc_pkg::BlockW-1:0] round_key,
  input  logic                          last,
  output logic [aesenc_pkg::BlockW-1:0] state_out
);

  logic [aesenc_pkg::BlockW-1:0] keyed;
  logic [aesenc_pkg::BlockW-1:0] shifted;
  logic [aesenc_pkg::BlockW-1:0] mixed;

  assign keyed = state_in ^ round_key;

  // SubBytes and ShiftRows: byte at row r, column c comes from column c+r.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shifted[aesenc_pkg::BlockW-1-8*(r+4*c) -: 8] =
          aesenc_pkg::sbox(aesenc_pkg::get_byte(keyed, r + 4*((c + r) % 4)));
      end
    end
  end

  // MixColumns over the four columns.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, all;
      a0  = aesenc_pkg::get_byte(shifted, 4*c);
      a1  = aesenc_pkg::get_byte(shifted, 4*c + 1);
      a2  = aesenc_pkg::get_byte(shifted, 4*c + 2);
      a3  = aesenc_pkg::get_byte(shifted, 4*c + 3);
      all = a0 ^ a1 ^ a2 ^ a3;
      mixed[aesenc_pkg::BlockW-1-8*(4*c)   -: 8] = a0 ^ all ^ aesenc_pkg::xtime(a0 ^ a1);
      mixed[aesenc_pkg::BlockW-1-8*(4*c+1) -: 8] = a1 ^ all ^ aesenc_pkg::xtime(a1 ^ a2);
      mixed[aesenc_pkg::BlockW-1-8*(4*c+2) -: 8] = a2 ^ all ^ aesenc_pkg::xtime(a2 ^ a3);
      mixed[aesenc_pkg::BlockW-1-8*(4*c+3) -: 8] = a3 ^ all ^ aesenc_pkg::xtime(a3 ^ a0);
    end
  end

  assign state_out = last ? shifted : mixed;

endmodule
